FILE: src/tesf_pkg.sv
`default_nettype none
package tesf_pkg;

  localparam int unsigned MarkerLen = 8;
  localparam int unsigned DepthW = 4;
  localparam int unsigned PosW = 5;
  localparam int unsigned FifoDepth = 2;

  localparam logic [1:0] KindData = 2'd0;
  localparam logic [1:0] KindTerm = 2'd1;
  localparam logic [1:0] KindError = 2'd2;

  localparam logic [0:0] CmdData = 1'b0;
  localparam logic [0:0] CmdEnd = 1'b1;

  localparam logic [0:0] DirPack = 1'b0;
  localparam logic [0:0] DirUnpack = 1'b1;

  localparam logic [2:0] AddrDirection = 3'd0;

  localparam logic [7:0] EscapeByte = 8'h01;
  localparam logic [7:0] TermByte = 8'h00;

  // one item's worth of output: held prefix, optional full marker, optional tail
  typedef struct packed {
    logic [DepthW-1:0] prefix;
    logic              full;
    logic              has_tail;
    logic [7:0]        tail_byte;
    logic [1:0]        tail_kind;
  } job_t;

  function automatic logic [7:0] marker_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h61;
      3'd1: b = 8'h62;
      3'd2: b = 8'h71;
      3'd3: b = 8'h64;
      3'd4: b = 8'h01;
      3'd5: b = 8'h66;
      3'd6: b = 8'h67;
      3'd7: b = 8'h68;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: src/token_escape_stream_framer.sv
// Byte-stream framer around the 8-byte marker "abqd",0x01,"fgh".
// Input stream: tdata[7:0] is a byte, tuser[0] set marks the end of the stream.
// Output stream: tdata[7:0] byte, tuser[1:0] kind (data, terminator, early end),
// tlast on the final result of each input item.
// direction register (APB address 0): 0 packs (escape 0x01 after every marker,
// marker plus 0x00 at the end), 1 unpacks (escape dropped, terminator and early
// end reported). Writing it restarts the framer; write only while idle.
// Front end accepts one byte per cycle while the job queue has room and turns
// it into a job that is queued; bytes that extend a marker match give no job.
// Back end emits one result per cycle while the receiver takes them, from the
// job at the queue head; an item gives up to 16 results (a pack end). A job
// is registered in the queue, then in the back end job register, before output.
// A stalled receiver holds the current result; the front keeps taking bytes
// until the job queue (FifoDepth entries) fills, then drops s_axis_tready.
// After the end of the stream, input items are taken and ignored until restart.
// Reset clears the match state, the queue and the direction (pack).
`default_nettype none
module token_escape_stream_framer #(
  parameter int unsigned FifoDepth = tesf_pkg::FifoDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser_i,   // [0] cmd
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [7:0] out_byte
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic           dir_q;
  logic           cfg_wr;
  logic           restart;
  logic           q_full, q_empty, q_push, q_pop;
  tesf_pkg::job_t q_wjob, q_rjob;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign restart = cfg_wr && (paddr == tesf_pkg::AddrDirection);
  assign prdata = (paddr == tesf_pkg::AddrDirection) ? {31'd0, dir_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= tesf_pkg::DirPack;
    end else if (restart) begin
      dir_q <= pwdata[0];
    end
  end

  tesf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dir_i       (dir_q),
    .restart_i   (restart),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i[0]),
    .data_byte_i (s_axis_tdata_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .job_o       (q_wjob)
  );

  tesf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wjob),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rjob),
    .empty_o (q_empty)
  );

  tesf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_rjob),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .kind_o      (m_axis_tuser_o),
    .last_o      (m_axis_tlast_o)
  );

endmodule
`default_nettype wire

FILE: src/tesf_front.sv
`default_nettype none
module tesf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              dir_i,
  input  wire logic              restart_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              cmd_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              q_full_i,
  output logic                   push_o,
  output tesf_pkg::job_t         job_o
);

  logic [tesf_pkg::DepthW-1:0] depth_q, depth_d;
  logic                        done_q, done_d;
  logic                        accept;
  logic                        held_full;
  logic                        match_next;
  logic [7:0]                  expect_byte;
  tesf_pkg::job_t              job;
  logic                        push;

  // items after the end are dropped, yet every item waits for queue space
  assign in_ready_o = !q_full_i;
  assign accept = in_valid_i && in_ready_o;

  assign held_full = (depth_q >= tesf_pkg::DepthW'(tesf_pkg::MarkerLen));
  assign expect_byte = tesf_pkg::marker_byte(depth_q[2:0]);
  assign match_next = !held_full && (data_byte_i == expect_byte);

  always_comb begin
    job = '0;
    push = 1'b0;
    depth_d = depth_q;
    done_d = done_q;
    if (accept && !done_q) begin
      if (dir_i == tesf_pkg::DirUnpack && held_full) begin
        depth_d = '0;
        push = 1'b1;
        if (cmd_i == tesf_pkg::CmdEnd) begin
          job.has_tail = 1'b1;
          job.tail_kind = tesf_pkg::KindError;
          done_d = 1'b1;
        end else if (data_byte_i == tesf_pkg::TermByte) begin
          job.has_tail = 1'b1;
          job.tail_kind = tesf_pkg::KindTerm;
          done_d = 1'b1;
        end else begin
          // escape byte is dropped, the marker goes out as data
          job.full = 1'b1;
        end
      end else if (cmd_i == tesf_pkg::CmdEnd) begin
        job.prefix = depth_q;
        job.has_tail = 1'b1;
        push = 1'b1;
        depth_d = '0;
        done_d = 1'b1;
        if (dir_i == tesf_pkg::DirPack) begin
          job.full = 1'b1;
          job.tail_byte = tesf_pkg::TermByte;
          job.tail_kind = tesf_pkg::KindData;
        end else begin
          job.tail_kind = tesf_pkg::KindError;
        end
      end else if (match_next) begin
        if (dir_i == tesf_pkg::DirPack &&
            depth_q == tesf_pkg::DepthW'(tesf_pkg::MarkerLen - 1)) begin
          job.full = 1'b1;
          job.has_tail = 1'b1;
          job.tail_byte = tesf_pkg::EscapeByte;
          job.tail_kind = tesf_pkg::KindData;
          push = 1'b1;
          depth_d = '0;
        end else begin
          depth_d = depth_q + 1'b1;
        end
      end else begin
        // mismatch: flush the held prefix, then recheck against the first marker byte
        job.prefix = depth_q;
        if (data_byte_i == tesf_pkg::marker_byte(3'd0)) begin
          depth_d = tesf_pkg::DepthW'(1);
          push = (depth_q != '0);
        end else begin
          job.has_tail = 1'b1;
          job.tail_byte = data_byte_i;
          job.tail_kind = tesf_pkg::KindData;
          depth_d = '0;
          push = 1'b1;
        end
      end
    end
    if (restart_i) begin
      depth_d = '0;
      done_d = 1'b0;
    end
  end

  assign push_o = push;
  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      done_q <= 1'b0;
    end else begin
      depth_q <= depth_d;
      done_q <= done_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/tesf_fifo.sv
`default_nettype none
module tesf_fifo #(
  parameter int unsigned Depth = tesf_pkg::FifoDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tesf_pkg::job_t wdata_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output tesf_pkg::job_t      rdata_o,
  output logic                empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tesf_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/tesf_back.sv
`default_nettype none
module tesf_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire tesf_pkg::job_t q_job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic [1:0]          kind_o,
  output logic                last_o
);

  tesf_pkg::job_t              job_q;
  logic                        busy_q;
  logic [tesf_pkg::PosW-1:0]   pos_q;
  logic [tesf_pkg::PosW-1:0]   total;
  logic [tesf_pkg::PosW-1:0]   prefix_w;
  logic [tesf_pkg::PosW-1:0]   marker_end;
  logic [tesf_pkg::PosW-1:0]   marker_pos;
  logic                        is_last;
  logic                        load;

  assign prefix_w = tesf_pkg::PosW'(job_q.prefix);
  assign marker_end = prefix_w +
                      (job_q.full ? tesf_pkg::PosW'(tesf_pkg::MarkerLen) : '0);
  assign total = marker_end + tesf_pkg::PosW'(job_q.has_tail);
  assign marker_pos = pos_q - prefix_w;
  assign is_last = (pos_q == total - 1'b1);

  always_comb begin
    out_byte_o = job_q.tail_byte;
    kind_o = job_q.tail_kind;
    if (pos_q < prefix_w) begin
      out_byte_o = tesf_pkg::marker_byte(pos_q[2:0]);
      kind_o = tesf_pkg::KindData;
    end else if (pos_q < marker_end) begin
      out_byte_o = tesf_pkg::marker_byte(marker_pos[2:0]);
      kind_o = tesf_pkg::KindData;
    end
  end

  assign out_valid_o = busy_q;
  assign last_o = is_last;
  assign load = (!busy_q || (out_ready_i && is_last)) && !q_empty_i;
  assign pop_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= q_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        pos_q <= '0;
      end else if (busy_q && out_ready_i) begin
        if (is_last) begin
          busy_q <= 1'b0;
          pos_q <= '0;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
